FILE: rtl/gppg_pkg.sv
// Types, constants and ROM content functions for the Gabor patch pixel generator.
// No dependencies; imported by gabor_patch_pixel_generator_core.
`default_nettype none

package gppg_pkg;

	typedef longint unsigned u64_t;

	localparam int COORD_BITS          = 12;
	localparam int EXP_TABLE_DEPTH_DEF  = 1024;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam u64_t Q30_ONE     = 64'd1073741824;
	localparam u64_t Q30_PI      = 64'd3373259426;
	localparam u64_t Q30_TWO_PI  = 64'd6746518852;
	localparam u64_t Q30_HALF_PI = 64'd1686629713;
	localparam u64_t Q30_INV_E   = 64'd395007542;

	localparam logic [31:0] AMP_THRESHOLD = 32'd8589934;
	localparam logic [7:0]  MID_GRAY      = 8'd127;
	localparam logic [7:0]  FULL_WHITE    = 8'd255;
	// 127.5 in the Q48 scale of amp * sine * 255
	localparam logic signed [57:0] GRAY_BIAS = 58'sd255 <<< 47;

	localparam logic [12:0]        CENTER_X_RST = 13'd0;
	localparam logic [12:0]        CENTER_Y_RST = 13'd0;
	localparam logic [31:0]        GAUSS_RST    = 32'd0;
	localparam logic signed [15:0] COS_RST      = 16'sd23170;
	localparam logic signed [15:0] SIN_RST      = 16'sd23170;
	localparam logic [23:0]        PHASE_RST    = 24'd0;
	localparam logic [15:0]        CONTRAST_RST = 16'd19661;

	typedef enum logic [2:0] {
		CFG_CENTER_X = 3'd0,
		CFG_CENTER_Y = 3'd1,
		CFG_GAUSS    = 3'd2,
		CFG_COS      = 3'd3,
		CFG_SIN      = 3'd4,
		CFG_PHASE    = 3'd5,
		CFG_CONTRAST = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} gppg_req_t;

	typedef struct packed {
		logic [7:0] gray_level;
		logic       in_envelope;
	} gppg_rsp_t;

	// unsigned floor quotient, only evaluated while building ROM contents
	function automatic u64_t div_u64(input u64_t num, input u64_t den);
		u64_t q;
		u64_t r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-t), t in Q3.30 below 8, result Q2.30
	function automatic u64_t exp_neg_q30(input u64_t t);
		u64_t   k;
		u64_t   f;
		u64_t   term;
		u64_t   v;
		longint acc;
		k    = t >> 30;
		f    = t & (Q30_ONE - 64'd1);
		term = Q30_ONE;
		acc  = longint'(Q30_ONE);
		for (int n = 1; n <= 16; n++) begin
			term = div_u64((term * f) >> 30, u64_t'(n));
			if ((n & 1) != 0) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		v = u64_t'(acc);
		for (int n = 0; n < 8; n++) begin
			if (u64_t'(n) < k) v = (v * Q30_INV_E) >> 30;
		end
		return v;
	endfunction

	function automatic logic [16:0] exp_entry(input u64_t t);
		return 17'((exp_neg_q30(t) + 64'd8192) >> 14);
	endfunction

	// sin(th), th in Q2.30 within 0..pi/2, result Q2.30
	function automatic u64_t sin_q30(input u64_t th);
		u64_t   term;
		longint acc;
		term = th;
		acc  = longint'(th);
		for (int n = 1; n <= 8; n++) begin
			term = (((term * th) >> 30) * th) >> 30;
			term = div_u64(term, u64_t'((2 * n) * (2 * n + 1)));
			if ((n & 1) != 0) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		if (u64_t'(acc) > Q30_ONE) acc = longint'(Q30_ONE);
		return u64_t'(acc);
	endfunction

	function automatic logic signed [15:0] sine_entry(input u64_t th_in);
		u64_t              th;
		u64_t              mag;
		logic              neg;
		logic signed [15:0] m;
		th  = th_in;
		neg = 1'b0;
		if (th > Q30_PI) begin
			th  = th - Q30_PI;
			neg = 1'b1;
		end
		if (th > Q30_HALF_PI) th = Q30_PI - th;
		mag = (sin_q30(th) * 64'd32767 + 64'd536870912) >> 30;
		m   = 16'(mag);
		return neg ? -m : m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gabor_patch_pixel_generator_core.sv
// Gabor patch pixel generator: one pixel coordinate in, one gray level out.
// Depends on gppg_pkg (types, constants, ROM content functions).
//
// Usage:
//   req channel (req_valid/req_ready/req) carries pixel_x, pixel_y. A request
//   is taken at a clock edge with req_valid and req_ready both high.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns gray_level and in_envelope
//   in request order, one result per request.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the seven
//   registers; cfg_ready is always high, unknown indexes are dropped. Write
//   only while no request is in flight.
// Timing:
//   11-stage pipeline, one request per clock sustained while rsp_ready stays high.
//   rsp_valid rises once a taken request reaches the last stage; the result
//   leaves at an edge with rsp_ready high. Depth is set by the squared distance,
//   phase and Gaussian products, the exp and sine ROM reads and the final
//   amplitude * sine * 255 scaling; no stage chains two multiplies or ROM reads.
// Stall:
//   each stage holds while the one after it is full and stalled; empty
//   stages keep filling, so req_ready drops only when all 11 stages are full.
// Reset:
//   clears all stage valid bits and loads register defaults. ROMs are
//   constant logic and need no fill after reset.
`default_nettype none

module gabor_patch_pixel_generator_core #(
	parameter int EXP_TABLE_DEPTH  = gppg_pkg::EXP_TABLE_DEPTH_DEF,
	parameter int SINE_TABLE_DEPTH = gppg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire gppg_pkg::gppg_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output gppg_pkg::gppg_rsp_t      rsp,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	import gppg_pkg::*;

	localparam int NST  = 11;
	localparam int CB   = COORD_BITS;
	localparam int DW   = ((CB + 1 > 13) ? CB + 1 : 13) + 1;
	localparam int D2W  = 2 * DW;
	localparam int D2HW = D2W - 16;
	localparam int PW   = D2W + 32;
	localparam int NYW  = CB + 18;
	localparam int PHW  = NYW + 25;
	localparam int EAW  = $clog2(EXP_TABLE_DEPTH);
	localparam int SAW  = $clog2(SINE_TABLE_DEPTH);

	// config registers
	logic [12:0]        cx_q, cy_q;
	logic [31:0]        gs_q;
	logic signed [15:0] cos_q, sin_q;
	logic [23:0]        ps_q;
	logic [15:0]        contrast_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q       <= CENTER_X_RST;
			cy_q       <= CENTER_Y_RST;
			gs_q       <= GAUSS_RST;
			cos_q      <= COS_RST;
			sin_q      <= SIN_RST;
			ps_q       <= PHASE_RST;
			contrast_q <= CONTRAST_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CENTER_X: cx_q       <= cfg_data[12:0];
				CFG_CENTER_Y: cy_q       <= cfg_data[12:0];
				CFG_GAUSS:    gs_q       <= cfg_data;
				CFG_COS:      cos_q      <= $signed(cfg_data[15:0]);
				CFG_SIN:      sin_q      <= $signed(cfg_data[15:0]);
				CFG_PHASE:    ps_q       <= cfg_data[23:0];
				CFG_CONTRAST: contrast_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// ROMs
	logic [16:0]        exp_rom  [EXP_TABLE_DEPTH];
	logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_exp_rom
		localparam u64_t        T     = (u64_t'(gi) << 33) / EXP_TABLE_DEPTH;
		localparam logic [16:0] E_VAL = exp_entry(T);
		assign exp_rom[gi] = E_VAL;
	end

	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sine_rom
		localparam u64_t               TH    = (u64_t'(gi) * Q30_TWO_PI) / SINE_TABLE_DEPTH;
		localparam logic signed [15:0] S_VAL = sine_entry(TH);
		assign sine_rom[gi] = S_VAL;
	end

	// stage handshake
	logic [NST-1:0] pipe_valid_q;
	logic [NST:0]   stage_rdy;

	assign stage_rdy[NST] = rsp_ready;
	for (genvar gk = 0; gk < NST; gk++) begin : g_rdy
		assign stage_rdy[gk] = !pipe_valid_q[gk] || stage_rdy[gk+1];
	end

	assign req_ready = stage_rdy[0];
	assign rsp_valid = pipe_valid_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_q <= '0;
		end else begin
			if (stage_rdy[0]) pipe_valid_q[0] <= req_valid;
			for (int k = 1; k < NST; k++) begin
				if (stage_rdy[k]) pipe_valid_q[k] <= pipe_valid_q[k-1];
			end
		end
	end

	// datapath registers
	logic signed [DW-1:0]    dx_s1, dy_s1;
	logic signed [CB+16:0]   ycos_s1, xsin_s1;
	logic [D2W-2:0]          dxsq_s2, dysq_s2;
	logic signed [NYW-1:0]   ny_s2;
	logic [D2W-1:0]          d2_s3;
	logic [38:0]             frac_s3;
	logic [47:0]             pl_s4;
	logic [D2HW+31:0]        ph_s4;
	logic [SAW-1:0]          sidx_s4;
	logic [PW-1:0]           p_s5;
	logic signed [15:0]      sine_s5, sine_s6, sine_s7, sine_s8;
	logic                    inr_s6, inr_s7;
	logic [EAW-1:0]          eidx_s6;
	logic [16:0]             env_s7;
	logic [31:0]             amp_s8;
	logic                    inenv_s9, inenv_s10;
	logic signed [48:0]      mul_s9;
	logic signed [57:0]      total_s10;
	gppg_rsp_t               rsp_s11;

	// combinational terms between stages
	logic signed [CB+16:0]   ycos_c, xsin_c;
	logic signed [D2W-1:0]   dxsq_c, dysq_c;
	logic signed [PHW-1:0]   phase_c;
	logic [47:0]             pl_c;
	logic [D2HW+31:0]        ph_c;
	logic [39+SAW:0]         sp_c;
	logic [32+EAW:0]         ep_c;
	logic [32:0]             ampp_c;
	logic signed [48:0]      mul_c;
	logic signed [57:0]      mul_w;
	logic signed [57:0]      total_c;
	logic [7:0]              gray_c;

	assign ycos_c  = $signed({1'b0, req.pixel_y}) * cos_q;
	assign xsin_c  = $signed({1'b0, req.pixel_x}) * sin_q;
	assign dxsq_c  = dx_s1 * dx_s1;
	assign dysq_c  = dy_s1 * dy_s1;
	assign phase_c = ny_s2 * $signed({1'b0, ps_q});
	assign pl_c    = d2_s3[15:0] * gs_q;
	assign ph_c    = d2_s3[D2W-1:16] * gs_q;
	assign sp_c    = frac_s3 * (SAW + 1)'(SINE_TABLE_DEPTH);
	assign ep_c    = p_s5[36:5] * (EAW + 1)'(EXP_TABLE_DEPTH);
	assign ampp_c  = contrast_q * (inr_s7 ? env_s7 : 17'd0);
	assign mul_c   = $signed({1'b0, amp_s8}) * sine_s8;
	assign mul_w   = 58'(mul_s9);
	assign total_c = GRAY_BIAS + (mul_w <<< 8) - mul_w;

	always_comb begin
		if (total_s10[57]) gray_c = 8'd0;
		else if (total_s10[56]) gray_c = FULL_WHITE;
		else gray_c = total_s10[55:48];
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[0]) begin
			dx_s1   <= $signed(DW'({req.pixel_x, 1'b0})) - $signed(DW'(cx_q));
			dy_s1   <= $signed(DW'({req.pixel_y, 1'b0})) - $signed(DW'(cy_q));
			ycos_s1 <= ycos_c;
			xsin_s1 <= xsin_c;
		end
		if (stage_rdy[1]) begin
			dxsq_s2 <= dxsq_c[D2W-2:0];
			dysq_s2 <= dysq_c[D2W-2:0];
			ny_s2   <= NYW'(ycos_s1) + NYW'(xsin_s1);
		end
		if (stage_rdy[2]) begin
			d2_s3   <= D2W'(dxsq_s2) + D2W'(dysq_s2);
			frac_s3 <= phase_c[38:0];
		end
		if (stage_rdy[3]) begin
			pl_s4   <= pl_c;
			ph_s4   <= ph_c;
			sidx_s4 <= sp_c[39 +: SAW];
		end
		if (stage_rdy[4]) begin
			p_s5    <= {ph_s4, 16'd0} + PW'(pl_s4);
			sine_s5 <= sine_rom[sidx_s4];
		end
		if (stage_rdy[5]) begin
			inr_s6  <= (p_s5[PW-1:37] == '0);
			eidx_s6 <= ep_c[32 +: EAW];
			sine_s6 <= sine_s5;
		end
		if (stage_rdy[6]) begin
			env_s7  <= exp_rom[eidx_s6];
			inr_s7  <= inr_s6;
			sine_s7 <= sine_s6;
		end
		if (stage_rdy[7]) begin
			amp_s8  <= ampp_c[32:1];
			sine_s8 <= sine_s7;
		end
		if (stage_rdy[8]) begin
			inenv_s9 <= (amp_s8 > AMP_THRESHOLD);
			mul_s9   <= mul_c;
		end
		if (stage_rdy[9]) begin
			inenv_s10 <= inenv_s9;
			total_s10 <= total_c;
		end
		if (stage_rdy[10]) begin
			rsp_s11.gray_level  <= inenv_s10 ? gray_c : MID_GRAY;
			rsp_s11.in_envelope <= inenv_s10;
		end
	end

	assign rsp = rsp_s11;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> pipe_valid_q[0])
		else $error("accepted request missing from first stage");

	a_mid_gray: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.in_envelope |-> rsp.gray_level == MID_GRAY)
		else $error("outside envelope but not mid-gray");

	a_contrast_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == CFG_CONTRAST
		|=> contrast_q == $past(cfg_data[15:0]))
		else $error("contrast write lost");

	a_stall_holds_s11: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid_q[NST-1] && !rsp_ready && pipe_valid_q[NST-2]
		|=> pipe_valid_q[NST-2] && pipe_valid_q[NST-1])
		else $error("stage ten advanced into a stalled output");

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for gabor_patch_pixel_generator_core: directed table, then randomized phases.
// Results are checked against an in-bench fixed-point Gabor predictor with its own tables, or pinned row values.
// Depends on gppg_pkg and gabor_patch_pixel_generator_core.
`timescale 1ns / 100ps

module tb;
	import gppg_pkg::*;

	typedef longint unsigned q64_t;

	localparam int   PERIOD      = 10;
	localparam int   EXP_DEPTH   = 1024;
	localparam int   SINE_DEPTH  = 1024;
	localparam q64_t ONE_Q30     = 64'd1073741824;
	localparam q64_t PI_Q30      = 64'd3373259426;
	localparam q64_t TWO_PI_Q30  = 64'd6746518852;
	localparam q64_t HALF_PI_Q30 = 64'd1686629713;
	localparam q64_t INV_E_Q30   = 64'd395007542;
	localparam q64_t AMP_LIMIT   = 64'd8589934;
	localparam logic [7:0] MID_LEVEL = 8'd127;
	localparam logic [2:0] REG_NONE  = 3'd7;
	localparam int   PHASES      = 6;
	localparam int   PHASE_ITEMS = 150;
	localparam int   HOLD_OFF    = 150;
	localparam int   QUIET_LIMIT = 2000;
	localparam int   DRAIN_WAIT  = 24;

	typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_t;
	typedef enum bit {CHK_MODEL, CHK_FIXED} row_check_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_idx;
		logic [31:0] reg_data;
		logic [11:0] px;
		logic [11:0] py;
		row_check_t  check;
		logic [7:0]  gray;
		logic        lit;
	} plan_row_t;

	localparam int PLAN_LEN = 39;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd0,    12'd0,    CHK_FIXED, MID_LEVEL, 1'b1},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4095, CHK_FIXED, MID_LEVEL, 1'b1},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd0,    CHK_FIXED, MID_LEVEL, 1'b1},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd0,    12'd4095, CHK_FIXED, MID_LEVEL, 1'b1},
		'{ROW_WRITE, CFG_CONTRAST, 32'hFFFF_0106, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd17,   12'd3000, CHK_FIXED, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CONTRAST, 32'h0000_0107, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_PHASE,    32'hFF12_3456, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd17,   12'd3000, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4095, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CONTRAST, 32'h0000_0000, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd2048, 12'd1024, CHK_FIXED, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CONTRAST, 32'h0000_FFFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_GAUSS,    32'hFFFF_FFFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd0,    12'd0,    CHK_FIXED, MID_LEVEL, 1'b1},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd1,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4095, CHK_FIXED, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CENTER_X, 32'hFFFF_FFFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CENTER_Y, 32'h0000_1FFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4095, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4094, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_COS,      32'hABCD_8000, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_SIN,      32'h0000_7FFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_PHASE,    32'h00FF_FFFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, REG_NONE,     32'hFFFF_FFFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4095, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4094, 12'd4095, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_GAUSS,    32'h0000_0400, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CENTER_X, 32'h0000_0800, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_CENTER_Y, 32'h0000_0800, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd1024, 12'd1024, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd1100, 12'd900,  CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_GAUSS,    32'h0000_0000, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_COS,      32'h0000_7FFF, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_WRITE, CFG_SIN,      32'h5555_8000, 12'd0,    12'd0,    CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd4095, 12'd4095, CHK_MODEL, MID_LEVEL, 1'b0},
		'{ROW_PIXEL, REG_NONE,     32'h0,         12'd0,    12'd4095, CHK_MODEL, MID_LEVEL, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	gppg_req_t   req;
	logic        rsp_valid;
	logic        rsp_ready;
	gppg_rsp_t   rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	// predictor copy of the register file
	logic [12:0]        ctr_x    = 13'd0;
	logic [12:0]        ctr_y    = 13'd0;
	logic [31:0]        gauss    = 32'd0;
	logic signed [15:0] cos_k    = 16'sd23170;
	logic signed [15:0] sin_k    = 16'sd23170;
	logic [23:0]        step     = 24'd0;
	logic [15:0]        contrast = 16'd19661;

	q64_t   exp_lut [EXP_DEPTH];
	longint sine_lut [SINE_DEPTH];

	gppg_rsp_t   gray_due_q [$];
	int unsigned fault_count = 0;
	int unsigned quiet_cycles = 0;
	bit          pressure_on = 1'b0;
	bit          pressure_done = 1'b0;

	gabor_patch_pixel_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// exp and sine tables, Taylor series in Q2.30
	initial begin
		q64_t   t;
		q64_t   th;
		q64_t   term;
		q64_t   v;
		q64_t   mag;
		longint acc;
		bit     neg;
		for (int i = 0; i < EXP_DEPTH; i++) begin
			t    = (q64_t'(i) << 33) / EXP_DEPTH;
			term = ONE_Q30;
			acc  = longint'(ONE_Q30);
			for (int n = 1; n <= 16; n++) begin
				term = ((term * (t & (ONE_Q30 - 1))) >> 30) / q64_t'(n);
				acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			v = q64_t'(acc);
			for (q64_t k = 0; k < (t >> 30); k++) v = (v * INV_E_Q30) >> 30;
			exp_lut[i] = (v + 64'd8192) >> 14;
		end
		for (int i = 0; i < SINE_DEPTH; i++) begin
			th  = (q64_t'(i) * TWO_PI_Q30) / SINE_DEPTH;
			neg = 1'b0;
			if (th > PI_Q30) begin
				th  = th - PI_Q30;
				neg = 1'b1;
			end
			if (th > HALF_PI_Q30) th = PI_Q30 - th;
			term = th;
			acc  = longint'(th);
			for (int n = 1; n <= 8; n++) begin
				term = ((((term * th) >> 30) * th) >> 30) / q64_t'(4 * n * n + 2 * n);
				acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			if (q64_t'(acc) > ONE_Q30) acc = longint'(ONE_Q30);
			mag = (q64_t'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
			sine_lut[i] = neg ? -longint'(mag) : longint'(mag);
		end
	end

	function automatic gppg_rsp_t gabor_gray(input gppg_req_t p);
		longint    dx;
		longint    dy;
		longint    ny;
		longint    total;
		q64_t      d2;
		q64_t      idx;
		q64_t      env;
		q64_t      amp;
		q64_t      frac;
		q64_t      sidx;
		gppg_rsp_t r;
		dx  = 2 * longint'(p.pixel_x) - longint'(ctr_x);
		dy  = 2 * longint'(p.pixel_y) - longint'(ctr_y);
		d2  = q64_t'(dx * dx + dy * dy);
		env = 0;
		// envelope is zero once the exponent reaches 8
		if (gauss == 0 || d2 <= ((64'd1 << 37) - 1) / q64_t'(gauss)) begin
			idx = ((((d2 * q64_t'(gauss)) >> 2) >> 3) * EXP_DEPTH) >> 32;
			if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
			env = exp_lut[idx];
		end
		amp = (q64_t'(contrast) * env) >> 1;
		if (amp > AMP_LIMIT) begin
			ny   = longint'(p.pixel_y) * longint'(cos_k) + longint'(p.pixel_x) * longint'(sin_k);
			frac = (q64_t'(ny) * q64_t'(step)) & ((64'd1 << 39) - 1);
			sidx = (frac * SINE_DEPTH) >> 39;
			if (sidx >= SINE_DEPTH) sidx = SINE_DEPTH - 1;
			total = (longint'(255) <<< 47) + longint'(amp) * sine_lut[sidx] * 255;
			if (total < 0) total = 0;
			total = total >>> 48;
			if (total > 255) total = 255;
			r.gray_level  = 8'(total);
			r.in_envelope = 1'b1;
		end else begin
			r.gray_level  = MID_LEVEL;
			r.in_envelope = 1'b0;
		end
		return r;
	endfunction

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
		req_valid <= 1'b0;
		while (gray_due_q.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CENTER_X: ctr_x    = data[12:0];
			CFG_CENTER_Y: ctr_y    = data[12:0];
			CFG_GAUSS:    gauss    = data;
			CFG_COS:      cos_k    = data[15:0];
			CFG_SIN:      sin_k    = data[15:0];
			CFG_PHASE:    step     = data[23:0];
			CFG_CONTRAST: contrast = data[15:0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input bit pinned,
			input gppg_rsp_t pinned_rsp);
		gppg_req_t p;
		p.pixel_x = x;
		p.pixel_y = y;
		cfg_valid <= 1'b0;
		req_valid <= 1'b1;
		req       <= p;
		do @(posedge clk); while (!req_ready);
		gray_due_q.push_back(pinned ? pinned_rsp : gabor_gray(p));
	endtask

	initial begin
		int          burst_left;
		int          pick;
		int          span;
		int          off;
		int          cx;
		int          cy;
		logic [31:0] raw;
		logic [31:0] data;
		gppg_rsp_t   fixed_rsp;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_WRITE) begin
				cfg_write(PLAN[i].reg_idx, PLAN[i].reg_data);
			end else begin
				fixed_rsp.gray_level  = PLAN[i].gray;
				fixed_rsp.in_envelope = PLAN[i].lit;
				send_pixel(PLAN[i].px, PLAN[i].py, PLAN[i].check == CHK_FIXED, fixed_rsp);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			for (int r = int'(CFG_CENTER_X); r <= int'(CFG_CONTRAST); r++) begin
				pick = $urandom_range(0, 3);
				raw  = $urandom;
				data = raw;
				case (3'(r))
					CFG_CENTER_X, CFG_CENTER_Y: begin
						if (pick == 0) data = {raw[31:13], 13'h0000};
						if (pick == 1) data = {raw[31:13], 13'h1FFF};
					end
					CFG_GAUSS: begin
						if (pick == 0) data = 32'h0;
						else if (pick == 1) data = 32'hFFFF_FFFF;
						else data = raw >> $urandom_range(0, 31);
					end
					CFG_COS, CFG_SIN: begin
						if (pick == 0) data = {raw[31:16], 16'h8000};
						if (pick == 1) data = {raw[31:16], 16'h7FFF};
					end
					CFG_PHASE: begin
						if (pick == 0) data = {raw[31:24], 24'h000000};
						if (pick == 1) data = {raw[31:24], 24'hFFFFFF};
					end
					default: begin
						if (pick == 0) data = {raw[31:16], 16'h0000};
						if (pick == 1) data = {raw[31:16], 16'hFFFF};
					end
				endcase
				cfg_write(3'(r), data);
			end
			if ($urandom_range(0, 2) == 0) cfg_write(REG_NONE, $urandom);

			// long receiver hold-off lands while this phase keeps offering requests
			if (ph == 0) pressure_on = 1'b1;

			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					req_valid <= 1'b0;
					cfg_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				if ($urandom_range(0, 4) == 0) begin
					cx = $urandom_range(0, 4095);
					cy = $urandom_range(0, 4095);
				end else begin
					// cluster around the patch center
					span = 1 << $urandom_range(0, 11);
					off  = $urandom_range(0, 2 * span);
					cx   = int'(ctr_x >> 1) + off - span;
					off  = $urandom_range(0, 2 * span);
					cy   = int'(ctr_y >> 1) + off - span;
					if (cx < 0) cx = 0;
					if (cx > 4095) cx = 4095;
					if (cy < 0) cy = 0;
					if (cy > 4095) cy = 4095;
				end
				send_pixel(12'(cx), 12'(cy), 1'b0, fixed_rsp);
			end
		end

		req_valid <= 1'b0;
		while (gray_due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fault_count == 0) begin
			$display("gabor_patch_pixel_generator_core verification clean");
		end else begin
			$display("gabor_patch_pixel_generator_core verification failed");
		end
		$finish;
	end

	// response side stall pattern, plus one long hold-off
	initial begin
		int seg;
		int mode;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (pressure_on && !pressure_done) begin
				pressure_done = 1'b1;
				repeat (HOLD_OFF) begin
					@(posedge clk);
					rsp_ready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 2);
			seg  = $urandom_range(4, 48);
			repeat (seg) begin
				@(posedge clk);
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					default: rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		gppg_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (gray_due_q.size() == 0) begin
				$error("gray_level %0d in_envelope %0d arrived with no request pending",
					rsp.gray_level, rsp.in_envelope);
				fault_count++;
			end else begin
				want = gray_due_q.pop_front();
				if (rsp.gray_level !== want.gray_level) begin
					$error("gray_level: expected %0d, got %0d", want.gray_level, rsp.gray_level);
					fault_count++;
				end
				if (rsp.in_envelope !== want.in_envelope) begin
					$error("in_envelope: expected %0d, got %0d", want.in_envelope,
						rsp.in_envelope);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("gabor_patch_pixel_generator_core verification failed");
				$finish;
			end
		end
	end

endmodule
